// ----- hw/rtl/rcw_pkg.sv -----
// Shared types, codes and constants of the RTO and congestion window control core.
// Used by every module of the core; depends on nothing else.
`timescale 1ns / 1ps

package rcw_pkg;

  localparam logic [1:0] CMD_RTT   = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_RTT   = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [2:0] REG_MAX_SEGMENT   = 3'd0;
  localparam logic [2:0] REG_TICK_INTERVAL = 3'd1;
  localparam logic [2:0] REG_MIN_RTO       = 3'd2;
  localparam logic [2:0] REG_SEND_WINDOW   = 3'd3;
  localparam logic [2:0] REG_NO_CONGESTION = 3'd4;
  localparam logic [2:0] REG_FAST_RESEND   = 3'd5;

  localparam logic [15:0] RTO_CEILING  = 16'd60000;
  localparam logic [15:0] RTO_RESET    = 16'd200;
  localparam logic [15:0] THRESH_FLOOR = 16'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int DIV_N     = 33;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic [13:0] max_segment;
    logic [12:0] tick_interval;
    logic [15:0] min_rto;
    logic [15:0] send_window;
    logic        no_congestion;
    logic [7:0]  fast_resend;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] rtt;
    logic [15:0] remote_window;
    logic [15:0] in_flight;
    logic        fast_seen;
    logic        lost_seen;
  } entry_t;

endpackage

// ----- hw/rtl/rcw_front.sv -----
// Front end: accepts input items, classifies the event and pushes it to the queue.
// Depends on rcw_pkg.
`timescale 1ns / 1ps

module rcw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  logic [31:0]     in_rtt,
  input  logic [15:0]     in_remote,
  input  logic [15:0]     in_flight,
  input  logic            in_fast,
  input  logic            in_lost,
  output logic            push,
  output rcw_pkg::entry_t push_entry,
  input  logic            q_full
);
  import rcw_pkg::*;

  logic   hold_valid;
  entry_t hold;
  entry_t cls;

  always_comb begin
    cls.rtt           = in_rtt[30:0];
    cls.remote_window = in_remote;
    cls.in_flight     = in_flight;
    cls.fast_seen     = in_fast;
    cls.lost_seen     = in_lost;
    unique case (in_cmd)
      CMD_RTT:   cls.kind = in_rtt[31] ? KIND_NONE : KIND_RTT;
      CMD_ACK:   cls.kind = KIND_ACK;
      CMD_FLUSH: cls.kind = KIND_FLUSH;
      default:   cls.kind = KIND_NONE;
    endcase
  end

  assign push       = hold_valid && !q_full;
  assign push_entry = hold;
  assign in_ready   = !rst && (!hold_valid || !q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= cls;
    end
  end

endmodule

// ----- hw/rtl/rcw_queue.sv -----
// Short event queue between the front end and the execution back end.
// Depends on rcw_pkg.
`timescale 1ns / 1ps

module rcw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcw_pkg::entry_t push_entry,
  input  logic            pop,
  output rcw_pkg::entry_t head,
  output logic            full,
  output logic            empty
);
  import rcw_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rcw_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rcw_pkg.
`timescale 1ns / 1ps

module rcw_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rcw_pkg::DIV_N-1:0] dividend,
  input  logic [31:0]            divisor,
  output logic                   done,
  output logic [rcw_pkg::DIV_N-1:0] quotient
);
  import rcw_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          den;
  logic [DIV_N-1:0]     quo;
  logic [32:0]          rem_sh;
  logic [33:0]          diff;
  logic                 take;

  assign rem_sh   = {rem, quo[DIV_N-1]};
  assign diff     = {1'b0, rem_sh} - {2'b0, den};
  assign take     = !diff[33];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= take ? diff[31:0] : rem_sh[31:0];
      quo <= {quo[DIV_N-2:0], take};
    end
  end

endmodule

// ----- hw/rtl/rcw_back.sv -----
// Back end: sequencer that carries out RTT, ACK and flush events on the state,
// with a shared multiplier, the serial divider and the result register.
// Depends on rcw_pkg and rcw_div.
`timescale 1ns / 1ps

module rcw_back (
  input  logic            clk,
  input  logic            rst,
  input  rcw_pkg::cfg_t   cfg,
  input  rcw_pkg::entry_t q_head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     out_data
);
  import rcw_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RTT1 = 5'd1;
  localparam logic [4:0] ST_RTT2 = 5'd2;
  localparam logic [4:0] ST_RTT3 = 5'd3;
  localparam logic [4:0] ST_RTT4 = 5'd4;
  localparam logic [4:0] ST_ACK1 = 5'd5;
  localparam logic [4:0] ST_ACK2 = 5'd6;
  localparam logic [4:0] ST_ACK3 = 5'd7;
  localparam logic [4:0] ST_ACK4 = 5'd8;
  localparam logic [4:0] ST_ACK5 = 5'd9;
  localparam logic [4:0] ST_ACK6 = 5'd10;
  localparam logic [4:0] ST_ACK7 = 5'd11;
  localparam logic [4:0] ST_ACK8 = 5'd12;
  localparam logic [4:0] ST_FL1  = 5'd13;
  localparam logic [4:0] ST_FL2  = 5'd14;
  localparam logic [4:0] ST_FL3  = 5'd15;
  localparam logic [4:0] ST_DONE = 5'd16;

  logic [4:0]  state;
  entry_t      ent;
  logic [31:0] srtt;
  logic [31:0] rvar;
  logic [15:0] rto;
  logic [15:0] win;
  logic [31:0] wb;
  logic [15:0] thr;
  logic [31:0] delta;
  logic [33:0] term;
  logic [15:0] eff_r;
  logic [30:0] mul_r;

  logic [13:0] mss;
  logic [15:0] rmt;
  logic [31:0] raw;
  logic [33:0] var_upd;
  logic [34:0] srtt_upd;
  logic [31:0] srtt_new;
  logic [33:0] var4;
  logic [33:0] tick34;
  logic [34:0] rto_sum;
  logic [34:0] rto_lo;
  logic [15:0] rto_cl;
  logic [15:0] eff_min;
  logic [15:0] eff_now;
  logic [15:0] fhalf;
  logic [15:0] fthr;
  logic [15:0] lhalf;
  logic [15:0] lthr;
  logic [15:0] resent;
  logic [16:0] mul_a;
  logic [30:0] mul_p;
  logic        div_start;
  logic [DIV_N-1:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [DIV_N-1:0] div_q;
  logic        mss_nz;
  logic        out_load;

  assign mss    = cfg.max_segment;
  assign mss_nz = (mss != '0);
  assign rmt    = ent.remote_window;
  assign raw    = {1'b0, ent.rtt};

  assign var_upd  = {1'b0, rvar, 1'b0} + {2'b0, rvar} + {2'b0, delta};
  assign srtt_upd = {srtt, 3'b0} - {3'b0, srtt} + {3'b0, raw};
  assign srtt_new = (srtt_upd[34:3] == '0) ? 32'd1 : srtt_upd[34:3];
  assign var4     = {rvar, 2'b0};
  assign tick34   = {21'b0, cfg.tick_interval};
  assign rto_sum  = {3'b0, srtt} + {1'b0, term};
  assign rto_lo   = (rto_sum < {19'b0, cfg.min_rto}) ? {19'b0, cfg.min_rto} : rto_sum;
  assign rto_cl   = (rto_lo > {19'b0, RTO_CEILING}) ? RTO_CEILING : rto_lo[15:0];

  assign eff_min = (cfg.send_window < rmt) ? cfg.send_window : rmt;
  assign eff_now = (!cfg.no_congestion && win < eff_min) ? win : eff_min;

  assign fhalf  = {1'b0, ent.in_flight[15:1]};
  assign fthr   = (fhalf < THRESH_FLOOR) ? THRESH_FLOOR : fhalf;
  assign lhalf  = {1'b0, eff_r[15:1]};
  assign lthr   = (lhalf < THRESH_FLOOR) ? THRESH_FLOOR : lhalf;
  assign resent = (cfg.fast_resend != '0) ? {8'b0, cfg.fast_resend} : 16'hffff;

  always_comb begin
    case (state)
      ST_ACK2: mul_a = {3'b0, mss};
      ST_ACK5: mul_a = {1'b0, win} + 17'd1;
      ST_ACK8: mul_a = {1'b0, rmt};
      ST_FL3:  mul_a = {1'b0, win};
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mss;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 32'd1;
    case (state)
      ST_ACK3: begin
        div_start    = 1'b1;
        div_dividend = {5'b0, mul_r[27:0]};
        div_divisor  = (wb == '0) ? 32'd1 : wb;
      end
      ST_ACK6: begin
        div_start    = ({1'b0, mul_r} <= wb);
        div_dividend = {1'b0, wb} + {19'b0, mss} - {32'b0, mss_nz};
        div_divisor  = mss_nz ? {18'b0, mss} : 32'd1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      srtt      <= '0;
      rvar      <= '0;
      rto       <= RTO_RESET;
      win       <= '0;
      wb        <= '0;
      thr       <= THRESH_FLOOR;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            ent <= q_head;
            unique case (q_head.kind)
              KIND_RTT:   state <= ST_RTT1;
              KIND_ACK:   state <= ST_ACK1;
              KIND_FLUSH: state <= ST_FL1;
              default:    state <= ST_DONE;
            endcase
          end
        end
        ST_RTT1: begin
          if (srtt == '0) begin
            srtt  <= raw;
            rvar  <= {1'b0, raw[31:1]};
            state <= ST_RTT3;
          end else begin
            delta <= (raw >= srtt) ? raw - srtt : srtt - raw;
            state <= ST_RTT2;
          end
        end
        ST_RTT2: begin
          rvar  <= var_upd[33:2];
          srtt  <= srtt_new;
          state <= ST_RTT3;
        end
        ST_RTT3: begin
          term  <= (var4 > tick34) ? var4 : tick34;
          state <= ST_RTT4;
        end
        ST_RTT4: begin
          rto   <= rto_cl;
          state <= ST_DONE;
        end
        ST_ACK1: begin
          if (win >= rmt) begin
            state <= ST_DONE;
          end else if (win < thr) begin
            win   <= win + 16'd1;
            wb    <= wb + {18'b0, mss};
            state <= ST_DONE;
          end else begin
            if (wb < {18'b0, mss}) begin
              wb <= {18'b0, mss};
            end
            state <= ST_ACK2;
          end
        end
        ST_ACK2: begin
          mul_r <= mul_p;
          state <= ST_ACK3;
        end
        ST_ACK3: begin
          state <= ST_ACK4;
        end
        ST_ACK4: begin
          if (div_done) begin
            wb    <= wb + div_q[31:0] + {22'b0, mss[13:4]};
            state <= ST_ACK5;
          end
        end
        ST_ACK5: begin
          mul_r <= mul_p;
          state <= ST_ACK6;
        end
        ST_ACK6: begin
          state <= div_start ? ST_ACK7 : ST_DONE;
        end
        ST_ACK7: begin
          if (div_done) begin
            if (div_q > {17'b0, rmt}) begin
              win   <= rmt;
              state <= ST_ACK8;
            end else begin
              win   <= div_q[15:0];
              state <= ST_DONE;
            end
          end
        end
        ST_ACK8: begin
          wb    <= {1'b0, mul_p};
          state <= ST_DONE;
        end
        ST_FL1: begin
          eff_r <= eff_now;
          state <= ST_FL2;
        end
        ST_FL2: begin
          if (ent.lost_seen) begin
            thr   <= lthr;
            win   <= 16'd1;
            wb    <= {18'b0, mss};
            state <= ST_DONE;
          end else if (ent.fast_seen) begin
            thr   <= fthr;
            win   <= fthr + resent;
            state <= ST_FL3;
          end else begin
            if (win == '0) begin
              win <= 16'd1;
              wb  <= {18'b0, mss};
            end
            state <= ST_DONE;
          end
        end
        ST_FL3: begin
          wb    <= {1'b0, mul_p};
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_data  <= {eff_now, thr, win, rto};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_thr_floor: assert property (@(posedge clk) disable iff (rst)
    thr >= THRESH_FLOOR)
    else $error("slow start threshold below floor");

  a_rto_ceiling: assert property (@(posedge clk) disable iff (rst)
    rto <= RTO_CEILING)
    else $error("retransmit timeout above ceiling");

  a_flush_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && ent.kind == KIND_FLUSH) |-> (win != '0))
    else $error("window left at zero after flush");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_ACK4 || state == ST_ACK7))
    else $error("divider finished outside a wait step");

endmodule

// ----- hw/rtl/rto_and_congestion_window_control_core.sv -----
// Top level of the RTO and congestion window control core; depends on rcw_pkg, rcw_front,
// rcw_queue, rcw_div and rcw_back. An ACK advance in congestion avoidance waits for one or
// two runs of the serial divider. One event executes at a time, while the input register
// and four-entry queue keep accepting items. Synchronous reset, no clearing.
`timescale 1ns / 1ps

module rto_and_congestion_window_control_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // rtt_sample, remote_window, in_flight,
                                     // fast_resend_seen, timeout_seen, zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // retransmit_timeout, congestion_window,
                                     // slow_start_threshold, effective_window
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rcw_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t q_head;
  logic   push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_segment   <= 14'd1376;
      cfg.tick_interval <= 13'd100;
      cfg.min_rto       <= 16'd100;
      cfg.send_window   <= 16'd32;
      cfg.no_congestion <= 1'b0;
      cfg.fast_resend   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_SEGMENT:   cfg.max_segment   <= cfg_data[13:0];
        REG_TICK_INTERVAL: cfg.tick_interval <= cfg_data[12:0];
        REG_MIN_RTO:       cfg.min_rto       <= cfg_data;
        REG_SEND_WINDOW:   cfg.send_window   <= cfg_data;
        REG_NO_CONGESTION: cfg.no_congestion <= cfg_data[0];
        REG_FAST_RESEND:   cfg.fast_resend   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_rtt     (s_axis_tdata[31:0]),
    .in_remote  (s_axis_tdata[47:32]),
    .in_flight  (s_axis_tdata[63:48]),
    .in_fast    (s_axis_tdata[64]),
    .in_lost    (s_axis_tdata[65]),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  rcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  rcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- tb/tb_rto_and_congestion_window_control_core.sv -----
// Self-checking testbench for rto_and_congestion_window_control_core: directed rows, then
// random items of all commands under six register settings, four with stalls on both sides.
// Depends on rcw_pkg and the core; results are compared with a predictor held in this file.
`timescale 1ns / 1ps

module tb_rto_and_congestion_window_control_core;
  import rcw_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         PHASES     = 6;
  localparam int         PHASE_ITEMS = 150;
  localparam int         DRAIN_CYCLES = 120;
  localparam int         LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [15:0] eff_win;
    logic [15:0] ssthresh;
    logic [15:0] cwnd;
    logic [15:0] rto;
  } win_report_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] rtt;
    logic [15:0] rmt;
    logic [15:0] flight;
    logic        fs;
    logic        ts;
    bit          typed;
    win_report_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  cfg_t        shadow_cfg;
  logic [31:0] est_srtt, est_rttvar, est_rto, est_cwnd, est_cwnd_bytes, est_ssthresh;

  win_report_t expected_reports[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned cycles;
  int          src_idle_pct;
  int          dst_idle_pct;

  rto_and_congestion_window_control_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic update_rtt(input logic [31:0] raw);
    logic [31:0] delta;
    logic [63:0] var4, floor_t, rto64;
    if (!raw[31]) begin
      if (est_srtt == 32'd0) begin
        est_srtt   = raw;
        est_rttvar = raw >> 1;
      end else begin
        delta      = (raw >= est_srtt) ? raw - est_srtt : est_srtt - raw;
        est_rttvar = 32'((64'd3 * 64'(est_rttvar) + 64'(delta)) >> 2);
        est_srtt   = 32'((64'd7 * 64'(est_srtt) + 64'(raw)) >> 3);
        if (est_srtt == 32'd0) est_srtt = 32'd1;
      end
      var4    = 64'(est_rttvar) << 2;
      floor_t = 64'(shadow_cfg.tick_interval);
      rto64   = 64'(est_srtt) + ((var4 > floor_t) ? var4 : floor_t);
      if (rto64 < 64'(shadow_cfg.min_rto)) rto64 = 64'(shadow_cfg.min_rto);
      if (rto64 > 64'(RTO_CEILING)) rto64 = 64'(RTO_CEILING);
      est_rto = 32'(rto64);
    end
  endtask

  task automatic grow_window(input logic [15:0] rmt);
    logic [31:0] mss, rmt32, q;
    logic [63:0] cw, num, den;
    mss   = 32'(shadow_cfg.max_segment);
    rmt32 = 32'(rmt);
    cw    = 64'(est_cwnd);
    if (est_cwnd < rmt32) begin
      if (est_cwnd < est_ssthresh) begin
        cw             = 64'(est_cwnd) + 64'd1;
        est_cwnd_bytes = est_cwnd_bytes + mss;
      end else begin
        if (est_cwnd_bytes < mss) est_cwnd_bytes = mss;
        q = (est_cwnd_bytes != 32'd0) ? (mss * mss) / est_cwnd_bytes : 32'd0;
        est_cwnd_bytes = est_cwnd_bytes + q + (mss >> 4);
        if ((64'(est_cwnd) + 64'd1) * 64'(mss) <= 64'(est_cwnd_bytes)) begin
          num = 64'(est_cwnd_bytes) + 64'(mss) + ((mss != 32'd0) ? 64'd0 : 64'd1) - 64'd1;
          den = (mss != 32'd0) ? 64'(mss) : 64'd1;
          cw  = num / den;
        end
      end
      if (cw > 64'(rmt32)) begin
        cw             = 64'(rmt32);
        est_cwnd_bytes = rmt32 * mss;
      end
      est_cwnd = 32'(cw);
    end
  endtask

  function automatic logic [31:0] usable_window(input logic [15:0] rmt);
    logic [31:0] eff;
    eff = (32'(shadow_cfg.send_window) < 32'(rmt)) ? 32'(shadow_cfg.send_window) : 32'(rmt);
    if (!shadow_cfg.no_congestion && est_cwnd < eff) eff = est_cwnd;
    return eff;
  endfunction

  task automatic shrink_window(input logic [15:0] rmt, input logic [15:0] flight,
                               input logic fs, input logic ts);
    logic [31:0] resent, eff, mss;
    mss    = 32'(shadow_cfg.max_segment);
    resent = (shadow_cfg.fast_resend != 8'd0) ? 32'(shadow_cfg.fast_resend) : 32'hffff_ffff;
    eff    = usable_window(rmt);
    if (fs) begin
      est_ssthresh = 32'(flight) >> 1;
      if (est_ssthresh < 32'(THRESH_FLOOR)) est_ssthresh = 32'(THRESH_FLOOR);
      est_cwnd       = (est_ssthresh + resent) & 32'h0000_ffff;
      est_cwnd_bytes = est_cwnd * mss;
    end
    if (ts) begin
      est_ssthresh = eff >> 1;
      if (est_ssthresh < 32'(THRESH_FLOOR)) est_ssthresh = 32'(THRESH_FLOOR);
      est_cwnd       = 32'd1;
      est_cwnd_bytes = mss;
    end
    if (est_cwnd < 32'd1) begin
      est_cwnd       = 32'd1;
      est_cwnd_bytes = mss;
    end
  endtask

  task automatic step_window_control(input logic [1:0] cmd, input logic [31:0] rtt,
                                     input logic [15:0] rmt, input logic [15:0] flight,
                                     input logic fs, input logic ts, output win_report_t rep);
    logic [31:0] eff;
    case (cmd)
      CMD_RTT:   update_rtt(rtt);
      CMD_ACK:   grow_window(rmt);
      CMD_FLUSH: shrink_window(rmt, flight, fs, ts);
      default: ;
    endcase
    eff          = usable_window(rmt);
    rep.rto      = est_rto[15:0];
    rep.cwnd     = est_cwnd[15:0];
    rep.ssthresh = est_ssthresh[15:0];
    rep.eff_win  = eff[15:0];
  endtask

  task automatic send_event(input logic [1:0] cmd, input logic [31:0] rtt,
                            input logic [15:0] rmt, input logic [15:0] flight,
                            input logic fs, input logic ts,
                            input bit typed, input win_report_t want);
    win_report_t model;
    @(negedge clk);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {6'b0, ts, fs, flight, rmt, rtt};
    do @(posedge clk); while (!s_axis_tready);
    step_window_control(cmd, rtt, rmt, flight, fs, ts, model);
    expected_reports.insert(expected_reports.size(), typed ? want : model);
  endtask

  task automatic send_random_event();
    logic [1:0]  cmd;
    logic [31:0] rtt;
    logic [15:0] rmt, flight;
    int unsigned sel;
    sel = $urandom_range(99, 0);
    cmd = (sel < 30) ? CMD_RTT : (sel < 70) ? CMD_ACK : (sel < 95) ? CMD_FLUSH : CMD_UNUSED;
    case ($urandom_range(9, 0))
      0:       rtt = $urandom();
      1:       rtt = 32'd0;
      2:       rtt = 32'h8000_0000 | $urandom();
      default: rtt = $urandom_range(3000, 1);
    endcase
    case ($urandom_range(9, 0))
      0:       rmt = 16'($urandom_range(65535, 0));
      1:       rmt = 16'd0;
      default: rmt = 16'($urandom_range(300, 1));
    endcase
    flight = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(65535, 0))
                                         : 16'($urandom_range(200, 0));
    send_event(cmd, rtt, rmt, flight, $urandom_range(99, 0) < 20, $urandom_range(99, 0) < 15,
               1'b0, '0);
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [31:0] rtt, input logic [15:0] rmt,
                         input logic [15:0] flight, input int fs, input int ts,
                         input int typed, input int rto, input int cwnd,
                         input int ssthresh, input int eff_win);
    stim_row_t r;
    r.cmd = cmd; r.rtt = rtt; r.rmt = rmt; r.flight = flight; r.fs = (fs != 0); r.ts = (ts != 0);
    r.typed = (typed != 0);
    r.want  = '{eff_win: 16'(eff_win), ssthresh: 16'(ssthresh), cwnd: 16'(cwnd),
                rto: 16'(rto)};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_SEGMENT:   shadow_cfg.max_segment   = value[13:0];
      REG_TICK_INTERVAL: shadow_cfg.tick_interval = value[12:0];
      REG_MIN_RTO:       shadow_cfg.min_rto       = value;
      REG_SEND_WINDOW:   shadow_cfg.send_window   = value;
      REG_NO_CONGESTION: shadow_cfg.no_congestion = value[0];
      REG_FAST_RESEND:   shadow_cfg.fast_resend   = value[7:0];
      default: ;
    endcase
  endtask

  // fields from index 0 up: max_segment, tick_interval, min_rto, send_window,
  // no_congestion, fast_resend
  function automatic logic [5:0][15:0] phase_setting(input int p);
    case (p)
      0:       return {16'd1,   16'd0, 16'd1,     16'd0,     16'd10,   16'd26};
      1:       return {16'd255, 16'd1, 16'd65535, 16'd60000, 16'd5000, 16'd9000};
      2:       return {16'd3,   16'd0, 16'd65535, 16'd65535, 16'd8191, 16'd16383};
      3:       return {16'd0,   16'd1, 16'd0,     16'd0,     16'd0,    16'd0};
      4:       return {16'd2,   16'd0, 16'd64,    16'd200,   16'd100,  16'd1376};
      default: return {16'd0,   16'd0, 16'd128,   16'd1000,  16'd20,   16'd536};
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report(input win_report_t got);
    win_report_t want;
    if (expected_reports.size() == 0) begin
      $error("result %h with nothing outstanding", got);
      mismatches++;
    end else begin
      want = expected_reports[0];
      expected_reports.delete(0);
      check_field("retransmit_timeout", want.rto, got.rto);
      check_field("congestion_window", want.cwnd, got.cwnd);
      check_field("slow_start_threshold", want.ssthresh, got.ssthresh);
      check_field("effective_window", want.eff_win, got.eff_win);
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_report(win_report_t'(m_axis_tdata));
      @(negedge clk);
      m_axis_tready = ($urandom_range(99, 0) >= dst_idle_pct);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_rto_and_congestion_window_control_core NOT OK");
    $finish;
  end

  initial begin
    logic [5:0][15:0] setting;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_RTT;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MAX_SEGMENT;
    cfg_data      = '0;
    mismatches    = 0;
    src_idle_pct  = 0;
    dst_idle_pct  = 0;

    shadow_cfg     = '{max_segment: 14'd1376, tick_interval: 13'd100, min_rto: 16'd100,
                       send_window: 16'd32, no_congestion: 1'b0, fast_resend: 8'd0};
    est_srtt       = 32'd0;
    est_rttvar     = 32'd0;
    est_rto        = 32'(RTO_RESET);
    est_cwnd       = 32'd0;
    est_cwnd_bytes = 32'd0;
    est_ssthresh   = 32'(THRESH_FLOOR);

    // unused command, negative sample, zero first sample, first sample, huge sample
    add_row(CMD_UNUSED, 32'd0,         16'd100,   16'd0, 0, 0, 1, 200,   0, 2, 0);
    add_row(CMD_RTT,    32'h8000_0000, 16'd0,     16'd0, 0, 0, 1, 200,   0, 2, 0);
    add_row(CMD_RTT,    32'd0,         16'd0,     16'd0, 0, 0, 1, 100,   0, 2, 0);
    add_row(CMD_RTT,    32'd1000,      16'd0,     16'd0, 0, 0, 1, 3000,  0, 2, 0);
    add_row(CMD_RTT,    32'h7fff_ffff, 16'd0,     16'd0, 0, 0, 1, 60000, 0, 2, 0);
    // window floor, slow start, avoidance, ack capped by the peer
    add_row(CMD_FLUSH,  32'd0, 16'hffff, 16'd0,    0, 0, 1, 60000, 1, 2, 1);
    add_row(CMD_ACK,    32'd0, 16'hffff, 16'd0,    0, 0, 1, 60000, 2, 2, 2);
    add_row(CMD_ACK,    32'd0, 16'hffff, 16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ACK,    32'd0, 16'd0,    16'd0,    0, 0, 0, 0, 0, 0, 0);
    // fast resend disabled, timeout, both at once, fast resend with nothing in flight
    add_row(CMD_FLUSH,  32'd0, 16'hffff, 16'hffff, 1, 0, 1, 60000, 32766, 32767, 32);
    add_row(CMD_FLUSH,  32'd0, 16'hffff, 16'd0,    0, 1, 1, 60000, 1, 16, 1);
    add_row(CMD_FLUSH,  32'd0, 16'd6,    16'd10,   1, 1, 1, 60000, 1, 2, 1);
    add_row(CMD_FLUSH,  32'd0, 16'hffff, 16'd0,    1, 0, 1, 60000, 1, 2, 1);
    add_row(CMD_ACK,    32'd0, 16'hffff, 16'd0,    0, 0, 1, 60000, 2, 2, 2);
    add_row(CMD_ACK,    32'd0, 16'hffff, 16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ACK,    32'd0, 16'hffff, 16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ACK,    32'd0, 16'hffff, 16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ACK,    32'd0, 16'd1,    16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_RTT,    32'd0, 16'd0,    16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_RTT,    32'd1, 16'd0,    16'd0,    0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_FLUSH,  32'd0, 16'd0,    16'hffff, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_UNUSED, 32'hffff_ffff, 16'hffff, 16'hffff, 1, 1, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_event(directed_rows[i].cmd, directed_rows[i].rtt, directed_rows[i].rmt,
                 directed_rows[i].flight, directed_rows[i].fs, directed_rows[i].ts,
                 directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      while (expected_reports.size() != 0) @(posedge clk);
      setting = phase_setting(p);
      cfg_write(REG_MAX_SEGMENT,   setting[REG_MAX_SEGMENT]);
      cfg_write(REG_TICK_INTERVAL, setting[REG_TICK_INTERVAL]);
      cfg_write(REG_MIN_RTO,       setting[REG_MIN_RTO]);
      cfg_write(REG_SEND_WINDOW,   setting[REG_SEND_WINDOW]);
      cfg_write(REG_NO_CONGESTION, setting[REG_NO_CONGESTION]);
      cfg_write(REG_FAST_RESEND,   setting[REG_FAST_RESEND]);
      @(negedge clk);
      cfg_valid = 1'b0;
      src_idle_pct = (p < 2) ? 15 : (p < 4) ? 85 : 0;
      dst_idle_pct = (p < 2) ? 85 : (p < 4) ? 15 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_event();
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_rto_and_congestion_window_control_core OK");
    end else begin
      $display("tb_rto_and_congestion_window_control_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rcw_pkg.sv
hw/rtl/rcw_front.sv
hw/rtl/rcw_queue.sv
hw/rtl/rcw_div.sv
hw/rtl/rcw_back.sv
hw/rtl/rto_and_congestion_window_control_core.sv
tb/tb_rto_and_congestion_window_control_core.sv
